// ===== rtl/core/lsag_pkg.sv =====
`default_nettype none

package lsag_pkg;

	localparam logic [63:0] MEMORY_BYTES = 64'd2097152;

	localparam logic [2:0] MODE_UOFF = 3'd0;
	localparam logic [2:0] MODE_ROFF = 3'd1;
	localparam logic [2:0] MODE_PRE  = 3'd2;
	localparam logic [2:0] MODE_POST = 3'd3;
	localparam logic [2:0] MODE_LIT  = 3'd4;
	localparam logic [2:0] MODE_NONE = 3'd5;

	localparam logic [1:0] FAULT_NONE = 2'd0;
	localparam logic [1:0] FAULT_MEM  = 2'd1;
	localparam logic [1:0] FAULT_ZR   = 2'd2;

	localparam logic [4:0] REG_ZR = 5'd31;

	typedef struct packed {
		logic [31:0] instruction;
		logic [63:0] pc;
		logic [63:0] base_value;
		logic [63:0] index_value;
	} lsag_req_t;

	typedef struct packed {
		logic [2:0]  mode;
		logic        is_load;
		logic        wide;
		logic [4:0]  target_reg;
		logic [4:0]  base_reg;
		logic [4:0]  index_reg;
		logic [63:0] address;
		logic        writeback;
		logic [63:0] writeback_value;
		logic [1:0]  fault;
		logic [63:0] next_pc;
	} lsag_res_t;

endpackage

`default_nettype wire

// ===== rtl/core/lsag_in_if.sv =====
`default_nettype none

interface lsag_in_if;
	logic        valid;
	logic        ready;
	logic [31:0] instruction;
	logic [63:0] pc;
	logic [63:0] base_value;
	logic [63:0] index_value;

	modport source (
		output valid, instruction, pc, base_value, index_value,
		input  ready
	);

	modport sink (
		input  valid, instruction, pc, base_value, index_value,
		output ready
	);
endinterface

`default_nettype wire

// ===== rtl/core/lsag_out_if.sv =====
`default_nettype none

interface lsag_out_if;
	logic        valid;
	logic        ready;
	logic [2:0]  mode;
	logic        is_load;
	logic        wide;
	logic [4:0]  target_reg;
	logic [4:0]  base_reg;
	logic [4:0]  index_reg;
	logic [63:0] address;
	logic        writeback;
	logic [63:0] writeback_value;
	logic [1:0]  fault;
	logic [63:0] next_pc;

	modport source (
		output valid, mode, is_load, wide, target_reg, base_reg, index_reg,
		address, writeback, writeback_value, fault, next_pc,
		input  ready
	);

	modport sink (
		input  valid, mode, is_load, wide, target_reg, base_reg, index_reg,
		address, writeback, writeback_value, fault, next_pc,
		output ready
	);
endinterface

`default_nettype wire

// ===== rtl/core/lsag_agu.sv =====
`default_nettype none

module lsag_agu (
	input  lsag_pkg::lsag_req_t req,
	output lsag_pkg::lsag_res_t res
);
	import lsag_pkg::*;

	logic [31:0] w;
	logic        transfer;
	logic        literal;
	logic        uoff;
	logic        roff;
	logic        prepost;
	logic        pre;
	logic [4:0]  rt;
	logic [4:0]  rn;
	logic [4:0]  rm;
	logic [63:0] opa;
	logic [63:0] opb;
	logic [63:0] sum;
	logic [63:0] checked;
	logic        zr_fault;
	logic        mem_fault;
	logic [1:0]  fault;
	logic [2:0]  mode;

	assign w        = req.instruction;
	assign transfer = w[31] & w[29];
	assign literal  = ~w[31] & ~w[29] & ~w[24];
	assign uoff     = transfer & w[24];
	assign roff     = transfer & ~w[24] & w[21];
	assign prepost  = transfer & ~w[24] & ~w[21];
	assign pre      = prepost & w[11];
	assign rt       = w[4:0];
	assign rn       = w[9:5];
	assign rm       = w[20:16];

	// one shared adder for every addressing form
	always_comb begin
		opa = literal ? req.pc : req.base_value;
		if (uoff) begin
			opb = w[30] ? {49'd0, w[21:10], 3'b000} : {50'd0, w[21:10], 2'b00};
		end else if (roff) begin
			opb = req.index_value;
		end else if (prepost) begin
			opb = {{55{w[20]}}, w[20:12]};
		end else begin
			opb = {{43{w[23]}}, w[23:5], 2'b00};
		end
	end

	assign sum     = opa + opb;
	assign checked = prepost ? req.base_value : sum;

	assign zr_fault  = (rt == REG_ZR) | (transfer & (rn == REG_ZR)) | (roff & (rm == REG_ZR));
	assign mem_fault = checked >= MEMORY_BYTES;

	always_comb begin
		if (zr_fault) begin
			fault = FAULT_ZR;
		end else if (mem_fault) begin
			fault = FAULT_MEM;
		end else begin
			fault = FAULT_NONE;
		end
	end

	always_comb begin
		if (uoff) begin
			mode = MODE_UOFF;
		end else if (roff) begin
			mode = MODE_ROFF;
		end else if (pre) begin
			mode = MODE_PRE;
		end else if (prepost) begin
			mode = MODE_POST;
		end else if (literal) begin
			mode = MODE_LIT;
		end else begin
			mode = MODE_NONE;
		end
	end

	always_comb begin
		res                 = '0;
		res.mode            = mode;
		res.next_pc         = req.pc;
		if (transfer || literal) begin
			res.is_load         = literal ? 1'b1 : w[22];
			res.wide            = w[30];
			res.target_reg      = rt;
			res.base_reg        = transfer ? rn : 5'd0;
			res.index_reg       = roff ? rm : 5'd0;
			res.address         = (prepost && !pre) ? req.base_value : sum;
			res.writeback_value = prepost ? sum : 64'd0;
			res.fault           = fault;
			res.writeback       = prepost && (fault == FAULT_NONE);
			if (fault == FAULT_NONE) begin
				res.next_pc = req.pc + 64'd4;
			end
		end
	end

endmodule

`default_nettype wire

// ===== rtl/core/load_store_address_generation_top.sv =====
// load/store address generation
//
// req carries one instruction word with the program counter and the values of
// the base and index registers; rsp returns the decoded access: mode, load or
// store, width, register numbers, effective address, base writeback and its
// value, fault code and next pc. both channels use valid/ready and a
// transaction moves on a rising clk edge with both high.
//
// the block is a two-register pipeline: an input register, then decode and a
// single 64-bit address adder with the memory-bound compare, then a result
// register. a transaction goes through the input register, then the result
// register to rsp; one per cycle moves each way while rsp.ready stays high.
//
// a stall on rsp holds the result register; the input register keeps taking
// a new transaction as long as it is empty or can move forward, so req.ready
// drops only when both registers are full and rsp.ready is low.
// arst_n clears both valid flags at once; no transaction is lost or repeated.
`default_nettype none

module load_store_address_generation_top (
	input  wire        clk,
	input  wire        arst_n,
	lsag_in_if.sink    req,
	lsag_out_if.source rsp
);
	import lsag_pkg::*;

	logic      valid_s1;
	logic      valid_s2;
	lsag_req_t req_s1;
	lsag_res_t res_s2;
	lsag_res_t res;
	logic      ready_s1;
	logic      ready_s2;

	assign ready_s2  = ~valid_s2 | rsp.ready;
	assign ready_s1  = ~valid_s1 | ready_s2;
	assign req.ready = ready_s1;

	lsag_agu u_agu (
		.req (req_s1),
		.res (res)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			valid_s2 <= 1'b0;
		end else begin
			if (ready_s1) begin
				valid_s1 <= req.valid;
			end
			if (ready_s2) begin
				valid_s2 <= valid_s1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (req.valid && ready_s1) begin
			req_s1.instruction <= req.instruction;
			req_s1.pc          <= req.pc;
			req_s1.base_value  <= req.base_value;
			req_s1.index_value <= req.index_value;
		end
		if (valid_s1 && ready_s2) begin
			res_s2 <= res;
		end
	end

	assign rsp.valid           = valid_s2;
	assign rsp.mode            = res_s2.mode;
	assign rsp.is_load         = res_s2.is_load;
	assign rsp.wide            = res_s2.wide;
	assign rsp.target_reg      = res_s2.target_reg;
	assign rsp.base_reg        = res_s2.base_reg;
	assign rsp.index_reg       = res_s2.index_reg;
	assign rsp.address         = res_s2.address;
	assign rsp.writeback       = res_s2.writeback;
	assign rsp.writeback_value = res_s2.writeback_value;
	assign rsp.fault           = res_s2.fault;
	assign rsp.next_pc         = res_s2.next_pc;

endmodule

`default_nettype wire
